// ===== hw/rtl/tpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types and constants of the timing profile table: request and result
// structs, slot row layout, request and status codes, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam int SLOT_COUNT_DEF = 32;
    localparam int TIME_BITS      = 48;
    localparam int KEY_BITS       = 32;
    localparam int SUM_BITS       = 64;
    localparam int SLOT_OUT_BITS  = 5;

    localparam logic [TIME_BITS-1:0] TIME_MASK = {TIME_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0] CALL_MAX  = {TIME_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]  SUM_MAX   = {SUM_BITS{1'b1}};

    typedef enum logic [1:0] {
        REQ_BEGIN = 2'd0,
        REQ_END   = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req_code;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } t_status_code;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [KEY_BITS-1:0]  section_key;
        logic [TIME_BITS-1:0] timestamp;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic [SLOT_OUT_BITS-1:0] slot_index;
        logic [TIME_BITS-1:0]     elapsed_ticks;
        logic [TIME_BITS-1:0]     call_count;
        logic [SUM_BITS-1:0]      total_ticks;
        logic [TIME_BITS-1:0]     min_first;
        logic [TIME_BITS-1:0]     min_second;
        logic [TIME_BITS-1:0]     max_first;
        logic [TIME_BITS-1:0]     max_second;
    } t_result;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [TIME_BITS-1:0] start_time;
        logic [SUM_BITS-1:0]  total_sum;
        logic [TIME_BITS-1:0] calls_done;
        logic [TIME_BITS-1:0] low_first;
        logic [TIME_BITS-1:0] low_second;
        logic [TIME_BITS-1:0] high_first;
        logic [TIME_BITS-1:0] high_second;
    } t_row;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_CALC,
        ST_UPDATE,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic load;
        logic clear_all;
        logic idx_inc;
        logic fail;
        logic claim;
        logic restart;
        logic calc;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_type;
        logic [1:0] req_type;
        logic       slot_free;
        logic       key_hit;
        logic       last_slot;
    } t_sts;

endpackage

// ===== hw/rtl/tpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpt_ctrl
// Controller of the timing profile table: walks the slots one at a time,
// decides claim, restart, update or failure, and paces the result strobe.
// ----------------------------------------------------------------------------
module tpt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_done,
    input  tpt_pkg::t_sts i_sts,
    output tpt_pkg::t_cmd o_cmd
);
    import tpt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_REPLY;
                    if (i_sts.in_type == REQ_BEGIN || i_sts.in_type == REQ_END) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.req_type == REQ_BEGIN) begin
                    if (i_sts.slot_free || i_sts.key_hit || i_sts.last_slot) begin
                        n_state = ST_REPLY;
                    end else begin
                        n_state = ST_READ;
                    end
                end else begin
                    if (i_sts.key_hit) begin
                        n_state = ST_CALC;
                    end else if (i_sts.last_slot) begin
                        n_state = ST_REPLY;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_CALC: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = ST_REPLY;
            end
            ST_REPLY: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        busy   = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
                if (start && i_sts.in_type == REQ_CLEAR) begin
                    o_cmd.clear_all = 1'b1;
                end
            end
            ST_READ: begin
            end
            ST_CHECK: begin
                if (i_sts.req_type == REQ_BEGIN) begin
                    if (i_sts.slot_free) begin
                        o_cmd.claim = 1'b1;
                    end else if (i_sts.key_hit) begin
                        o_cmd.restart = 1'b1;
                    end else if (i_sts.last_slot) begin
                        o_cmd.fail = 1'b1;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end else begin
                    if (i_sts.key_hit) begin
                    end else if (i_sts.last_slot) begin
                        o_cmd.fail = 1'b1;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            ST_REPLY: begin
                o_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/tpt_datapath.sv =====
// ----------------------------------------------------------------------------
// tpt_datapath
// Slot storage and arithmetic of the timing profile table: used flags, the
// slot row memory, the scan index, elapsed time, saturating totals, the
// two-deep minimum and maximum lists and the result register.
// ----------------------------------------------------------------------------
module tpt_datapath #(
    parameter int SLOT_COUNT = tpt_pkg::SLOT_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tpt_pkg::t_req    i_req,
    input  tpt_pkg::t_cmd    i_cmd,
    output tpt_pkg::t_sts    o_sts,
    output tpt_pkg::t_result o_result
);
    import tpt_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);

    t_row                  mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_used;
    t_row                  r_row;
    t_req                  r_req;
    logic [IDX_W-1:0]      r_idx;
    logic [TIME_BITS-1:0]  r_e;
    t_result               r_result;

    t_row                  n_row;
    logic                  n_wr;
    logic [SUM_BITS:0]     n_sum;

    // slot memory, registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            mem[r_idx] <= n_row;
        end
        r_row <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.clear_all) begin
            r_used <= '0;
        end else if (i_cmd.claim) begin
            r_used[r_idx] <= 1'b1;
        end
    end

    always_comb begin
        n_sum = {1'b0, r_row.total_sum} + {{(SUM_BITS + 1 - TIME_BITS){1'b0}}, r_e};
        n_row = r_row;
        n_wr  = i_cmd.claim | i_cmd.restart | i_cmd.update;
        if (i_cmd.claim) begin
            n_row.key         = r_req.section_key;
            n_row.start_time  = r_req.timestamp;
            n_row.total_sum   = '0;
            n_row.calls_done  = '0;
            n_row.low_first   = TIME_MASK;
            n_row.low_second  = TIME_MASK;
            n_row.high_first  = '0;
            n_row.high_second = '0;
        end else if (i_cmd.restart) begin
            n_row.start_time = r_req.timestamp;
        end else begin
            n_row.total_sum = n_sum[SUM_BITS] ? SUM_MAX : n_sum[SUM_BITS-1:0];
            if (r_row.calls_done != CALL_MAX) begin
                n_row.calls_done = r_row.calls_done + 1'b1;
            end
            if (r_e < r_row.low_first) begin
                n_row.low_second = r_row.low_first;
                n_row.low_first  = r_e;
            end else if (r_e < r_row.low_second) begin
                n_row.low_second = r_e;
            end
            if (r_e > r_row.high_first) begin
                n_row.high_second = r_row.high_first;
                n_row.high_first  = r_e;
            end else if (r_e > r_row.high_second) begin
                n_row.high_second = r_e;
            end
        end
    end

    // the result register is still clear from the load when a scan fails
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_idx    <= '0;
            r_result <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= IDX_W'(r_idx + 1'b1);
        end
        if (i_cmd.calc) begin
            r_e <= r_req.timestamp - r_row.start_time;
        end
        if (i_cmd.fail) begin
            if (r_req.req_type == REQ_BEGIN) begin
                r_result.status <= STATUS_FULL;
            end else begin
                r_result.status <= STATUS_NOT_FOUND;
            end
        end else if (n_wr) begin
            r_result.status        <= STATUS_OK;
            r_result.slot_index    <= SLOT_OUT_BITS'(r_idx);
            r_result.elapsed_ticks <= i_cmd.update ? r_e : '0;
            r_result.call_count    <= n_row.calls_done;
            r_result.total_ticks   <= n_row.total_sum;
            r_result.min_first     <= n_row.low_first;
            r_result.min_second    <= n_row.low_second;
            r_result.max_first     <= n_row.high_first;
            r_result.max_second    <= n_row.high_second;
        end
    end

    assign o_sts.in_type   = i_req.req_type;
    assign o_sts.req_type  = r_req.req_type;
    assign o_sts.slot_free = ~r_used[r_idx];
    assign o_sts.key_hit   = r_used[r_idx] && (r_row.key == r_req.section_key);
    assign o_sts.last_slot = (r_idx == IDX_W'(SLOT_COUNT - 1));
    assign o_result        = r_result;

endmodule

// ===== hw/rtl/timing_profile_table_core.sv =====
// ----------------------------------------------------------------------------
// timing_profile_table_core
// Table of named-section timing profiles keyed by a 32-bit section id.
//
// A request (begin, end or clear whole table) is taken on a rising edge with
// start high and busy low; busy stays high until the result has been shown.
// Each request gives one result on o_result, held for exactly one cycle with
// o_done high; the receiver takes it at the end of that cycle and cannot
// stall it.
// The slot memory is scanned one slot at a time, in a read state and then a
// compare state, from slot 0 up to the slot that matches or, for a begin, the
// first free one. An end then passes through a calc state for the elapsed
// time and an update state for the statistics. A full table or a missing key
// scans every slot. Clear and unused request codes answer in the next cycle.
// A new request is taken from the cycle after o_done.
// Reset marks every slot free; no memory pass is needed, and a request may
// start in the first cycle after reset.
// ----------------------------------------------------------------------------
module timing_profile_table_core #(
    parameter int SLOT_COUNT = tpt_pkg::SLOT_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tpt_pkg::t_req    i_req,
    output logic             o_done,
    output tpt_pkg::t_result o_result
);
    import tpt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tpt_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule
